/* sv/scs_pkg.sv */
// Shared constants, types and the arctangent table of the scaled sinc unit.
// Depends on nothing; every other file of the unit imports it.
package scs_pkg;

	// Number of rotation steps, limited to the length of the arctangent table.
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

	// Quotient bits produced by the restoring divider.
	localparam int QBITS = 23;

	// Angle constants in Q24.
	localparam logic signed [27:0] ANG_TWO_PI  = 28'sd105414357;
	localparam logic signed [27:0] ANG_PI      = 28'sd52707179;
	localparam logic signed [27:0] ANG_HALF_PI = 28'sd26353589;
	localparam logic signed [27:0] INV_GAIN    = 28'sd10188014;
	localparam logic [30:0]        MAG_TWO_PI  = 31'd105414357;
	localparam logic [30:0]        SMALL_PHASE = 31'd131072;

	// Result values in Q1.14.
	localparam logic signed [15:0] SINC_ONE = 16'sd16384;
	localparam logic signed [15:0] SINC_MAX = 16'sd32767;
	localparam logic signed [15:0] SINC_MIN = -16'sd32768;

	// Control that travels with each item through the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
		logic near_zero;
	} ctl_t;

	// atan(2^-i) in Q24, rounded to nearest.
	function automatic logic signed [27:0] atan_q24(input int i);
		logic signed [27:0] v;
		unique case (i)
			0: v = 28'sd13176795;
			1: v = 28'sd7778716;
			2: v = 28'sd4110060;
			3: v = 28'sd2086331;
			4: v = 28'sd1047214;
			5: v = 28'sd524117;
			6: v = 28'sd262123;
			7: v = 28'sd131069;
			8: v = 28'sd65536;
			9: v = 28'sd32768;
			10: v = 28'sd16384;
			11: v = 28'sd8192;
			12: v = 28'sd4096;
			13: v = 28'sd2048;
			14: v = 28'sd1024;
			15: v = 28'sd512;
			16: v = 28'sd256;
			17: v = 28'sd128;
			18: v = 28'sd64;
			19: v = 28'sd32;
			20: v = 28'sd16;
			21: v = 28'sd8;
			22: v = 28'sd4;
			default: v = 28'sd2;
		endcase
		return v;
	endfunction

endpackage

/* sv/scs_reduce.sv */
// Phase product, reduction modulo 2*pi and folding into [-pi/2, pi/2].
// Depends on scs_pkg.
module scs_reduce import scs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [15:0] scale_factor,
	input  logic               in_valid,
	input  logic signed [15:0] x_sample,
	input  logic               last_in,
	output ctl_t               ctl_out,
	output logic signed [27:0] angle_out,
	output logic [30:0]        mag_out
);

	// Stage 0 holds the magnitude of the product, stages 1 to 4 subtract
	// 8, 4, 2 and 1 times 2*pi.
	ctl_t        ctl_s [0:4];
	logic [30:0] mag_s [0:4];
	logic [30:0] phase_s [0:4];

	logic signed [31:0] prod;
	logic [31:0]        absp;

	// Exact phase product and its magnitude.
	always_comb begin
		prod = scale_factor * x_sample;
		absp = prod[31] ? 32'(-prod) : 32'(prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= '{valid: in_valid, last: last_in,
				near_zero: (absp[30:0] < SMALL_PHASE)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s[0]   <= absp[30:0];
			phase_s[0] <= absp[30:0];
		end
	end

	// Conditional subtraction of a multiple of 2*pi, one per stage.
	for (genvar j = 1; j <= 4; j++) begin : g_mod
		localparam logic [30:0] K = 31'(MAG_TWO_PI << (4 - j));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else if (en) begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s[j]   <= mag_s[j-1];
				phase_s[j] <= (phase_s[j-1] >= K) ? phase_s[j-1] - K : phase_s[j-1];
			end
		end
	end

	// Fold the remainder into [-pi/2, pi/2].
	logic signed [27:0] r0, r1, r2;

	always_comb begin
		r0 = signed'(phase_s[4][27:0]);
		r1 = (r0 > ANG_PI) ? r0 - ANG_TWO_PI : r0;
		if (r1 > ANG_HALF_PI) begin
			r2 = ANG_PI - r1;
		end else if (r1 < -ANG_HALF_PI) begin
			r2 = -ANG_PI - r1;
		end else begin
			r2 = r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_s[4];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_out <= r2;
			mag_out   <= mag_s[4];
		end
	end

endmodule

/* sv/scs_cordic.sv */
// Rotation-mode CORDIC giving the sine of a Q24 angle, one step per stage.
// Depends on scs_pkg.
module scs_cordic import scs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               ctl_in,
	input  logic signed [27:0] angle_in,
	input  logic [30:0]        mag_in,
	output ctl_t               ctl_out,
	output logic signed [27:0] sin_out,
	output logic [30:0]        mag_out
);

	ctl_t               ctl_s [0:NSTG-1];
	logic [30:0]        mag_s [0:NSTG-1];
	logic signed [27:0] cx_s  [0:NSTG-1];
	logic signed [27:0] cy_s  [0:NSTG-1];
	logic signed [27:0] z_s   [0:NSTG-1];

	for (genvar i = 0; i < NSTG; i++) begin : g_step
		ctl_t               c_i;
		logic [30:0]        m_i;
		logic signed [27:0] x_i, y_i, z_i;

		// Step i takes the port for the first stage, else the previous stage.
		if (i == 0) begin : g_first
			assign c_i = ctl_in;
			assign m_i = mag_in;
			assign x_i = INV_GAIN;
			assign y_i = '0;
			assign z_i = angle_in;
		end else begin : g_next
			assign c_i = ctl_s[i-1];
			assign m_i = mag_s[i-1];
			assign x_i = cx_s[i-1];
			assign y_i = cy_s[i-1];
			assign z_i = z_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= c_i;
			end
		end

		// Rotate towards a zero residual angle.
		always_ff @(posedge clk) begin
			if (en) begin
				mag_s[i] <= m_i;
				if (!z_i[27]) begin
					cx_s[i] <= x_i - (y_i >>> i);
					cy_s[i] <= y_i + (x_i >>> i);
					z_s[i]  <= z_i - atan_q24(i);
				end else begin
					cx_s[i] <= x_i + (y_i >>> i);
					cy_s[i] <= y_i - (x_i >>> i);
					z_s[i]  <= z_i + atan_q24(i);
				end
			end
		end
	end

	assign ctl_out = ctl_s[NSTG-1];
	assign sin_out = cy_s[NSTG-1];
	assign mag_out = mag_s[NSTG-1];

endmodule

/* sv/scs_divide.sv */
// Restoring divider forming round(sin * 2^14 / |phase|), then saturation.
// Depends on scs_pkg.
module scs_divide import scs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               ctl_in,
	input  logic signed [27:0] sin_in,
	input  logic [30:0]        mag_in,
	output ctl_t               ctl_out,
	output logic signed [15:0] sinc_value
);

	ctl_t             ctl_s [0:QBITS];
	logic             neg_s [0:QBITS];
	logic [30:0]      mag_s [0:QBITS];
	logic [39:0]      rem_s [0:QBITS];
	logic [QBITS-1:0] q_s   [0:QBITS];

	logic [27:0] abs_sin;

	// Rounded numerator: |s| * 2^14 + |p| / 2.
	assign abs_sin = sin_in[27] ? 28'(-sin_in) : 28'(sin_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= sin_in[27];
			mag_s[0] <= mag_in;
			rem_s[0] <= (40'(abs_sin) << 14) + 40'(mag_in >> 1);
			q_s[0]   <= '0;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 1; j <= QBITS; j++) begin : g_bit
		localparam int K = QBITS - j;
		logic take;

		assign take = (rem_s[j-1] >> K) >= 40'(mag_s[j-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else if (en) begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[j] <= neg_s[j-1];
				mag_s[j] <= mag_s[j-1];
				rem_s[j] <= take ? rem_s[j-1] - (40'(mag_s[j-1]) << K) : rem_s[j-1];
				q_s[j]   <= q_s[j-1] | (take ? (QBITS'(1) << K) : '0);
			end
		end
	end

	// Apply the sign, saturate, and force 1.0 for a small phase.
	logic signed [15:0] res;
	logic [QBITS-1:0]   qm;

	always_comb begin
		qm = q_s[QBITS];
		if (ctl_s[QBITS].near_zero) begin
			res = SINC_ONE;
		end else if (neg_s[QBITS]) begin
			res = (qm >= QBITS'(32768)) ? SINC_MIN : 16'(-signed'({1'b0, qm}));
		end else begin
			res = (qm > QBITS'(32767)) ? SINC_MAX : signed'(qm[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sinc_value <= res;
		end
	end

endmodule

/* sv/scaled_sinc_unit.sv */
// Top level of the scaled sinc unit: stream ports, scale register, pipeline.
// Depends on scs_pkg, scs_reduce, scs_cordic and scs_divide.

// Computes sin(a*x)/(a*x) in Q1.14 for each Q4.12 sample x, with the scale a
// held in a Q4.12 register (reset value 1.0) written over the cfg channel; the
// user must write it only while the unit is idle; the block does not enforce
// this. One item is taken per clock cycle unless the output stalls; the CORDIC
// takes one step per stage and the divider forms one quotient bit per stage.
// The whole pipeline advances together and holds while the output is stalled.
// A phase below 2^-7 rad gives exactly 1.0; tlast follows its sample.
module scaled_sinc_unit import scs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,       // scale_factor
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] x_sample
	input  logic        s_axis_tlast,   // last_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sinc_value
	output logic        m_axis_tlast    // last_out
);

	logic signed [15:0] scale_q;
	logic               en;

	ctl_t               ctl_r, ctl_c, ctl_d;
	logic signed [27:0] angle, sin_v;
	logic [30:0]        mag_r, mag_c;
	logic signed [15:0] sinc_value;

	// Scale register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 16'sd4096;
		end else if (cfg_valid) begin
			scale_q <= signed'(cfg_data);
		end
	end

	// The pipeline moves unless a finished item waits at the output.
	assign en            = !ctl_d.valid || m_axis_tready;
	assign s_axis_tready = en;

	scs_reduce u_reduce (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.scale_factor (scale_q),
		.in_valid     (s_axis_tvalid),
		.x_sample     (signed'(s_axis_tdata)),
		.last_in      (s_axis_tlast),
		.ctl_out      (ctl_r),
		.angle_out    (angle),
		.mag_out      (mag_r)
	);

	scs_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_in   (ctl_r),
		.angle_in (angle),
		.mag_in   (mag_r),
		.ctl_out  (ctl_c),
		.sin_out  (sin_v),
		.mag_out  (mag_c)
	);

	scs_divide u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_in     (ctl_c),
		.sin_in     (sin_v),
		.mag_in     (mag_c),
		.ctl_out    (ctl_d),
		.sinc_value (sinc_value)
	);

	assign m_axis_tvalid = ctl_d.valid;
	assign m_axis_tdata  = sinc_value;
	assign m_axis_tlast  = ctl_d.last;

endmodule

/* dv/scaled_sinc_unit_test.sv */
// Self-checking testbench of the scaled sinc unit: directed table, zero scale, then random samples.
// Depends on scs_pkg and scaled_sinc_unit; the expected values come from the table or a local predictor.
module scaled_sinc_unit_test;
	import scs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;

	typedef struct {
		logic [15:0] sinc;
		logic        last;
	} sinc_item_t;

	typedef struct {
		logic [15:0] x;
		logic        last;
		logic        known;
		logic [15:0] sinc;
	} stim_row_t;

	sinc_item_t pending_sinc[$];
	logic signed [15:0] scale_reg;
	int  fail_count;
	bit  out_quiet;
	bit  in_quiet;

	scaled_sinc_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor shift of a signed value.
	function automatic longint floor_shift(longint v, int s);
		if (v >= 0) return v >>> s;
		return -((-v - 1) >>> s) - 1;
	endfunction

	// Predicted sinc of a*x in Q1.14.
	function automatic logic [15:0] sinc_of(logic signed [15:0] a, logic signed [15:0] x);
		longint p, mag, r, cx, cy, z, dx, dy, num, anum, q;
		p = longint'(a) * longint'(x);
		mag = (p < 0) ? -p : p;
		if (mag < 131072) return 16'd16384;
		r = mag % 105414357;
		if (r > 52707179) r -= 105414357;
		if (r > 26353589) r = 52707179 - r;
		else if (r < -26353589) r = -52707179 - r;
		cx = 10188014;
		cy = 0;
		z = r;
		for (int i = 0; i < NSTG; i++) begin
			dx = floor_shift(cy, i);
			dy = floor_shift(cx, i);
			if (z >= 0) begin
				cx -= dx; cy += dy; z -= longint'(atan_q24(i));
			end else begin
				cx += dx; cy -= dy; z += longint'(atan_q24(i));
			end
		end
		num = cy * 16384;
		anum = (num < 0) ? -num : num;
		q = (anum + mag / 2) / mag;
		if (num < 0) q = -q;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	// Write the scale register once the unit has drained.
	task automatic write_scale(logic [15:0] v);
		while (pending_sinc.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		scale_reg = v;
	endtask

	// Offer one item, with random idling before it, and queue its expectation.
	task automatic send_sample(logic [15:0] x, logic last, logic known, logic [15:0] want);
		sinc_item_t e;
		if (!in_quiet) begin
			while ($urandom_range(99) < 29) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		e.sinc = known ? want : sinc_of(scale_reg, x);
		e.last = last;
		pending_sinc.push_back(e);
		@(negedge clk);
	endtask

	// Receiver stall pattern.
	always @(negedge clk) begin
		m_axis_tready <= out_quiet ? 1'b1 : ($urandom_range(99) >= 29);
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		sinc_item_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_sinc.size() == 0) begin
				$error("unexpected result sinc_value=%0d", $signed(m_axis_tdata));
				fail_count++;
			end else begin
				e = pending_sinc.pop_front();
				if (m_axis_tdata !== e.sinc) begin
					$error("sinc_value expected %0d actual %0d", $signed(e.sinc),
						$signed(m_axis_tdata));
					fail_count++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last_out expected %0b actual %0b", e.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		logic [15:0] scales[$];
		logic [15:0] xv;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		fail_count = 0;
		out_quiet = 1'b0;
		in_quiet = 1'b0;
		scale_reg = 16'sd4096;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at the reset scale of 1.0.
		rows.push_back('{16'h0000, 1'b0, 1'b1, 16'd16384});
		rows.push_back('{16'h0001, 1'b1, 1'b1, 16'd16384});
		rows.push_back('{16'hFFFF, 1'b0, 1'b1, 16'd16384});
		rows.push_back('{16'h001F, 1'b0, 1'b1, 16'd16384});
		rows.push_back('{16'h0020, 1'b0, 1'b0, 16'd0});
		rows.push_back('{16'hFFE0, 1'b1, 1'b0, 16'd0});
		rows.push_back('{16'h7FFF, 1'b0, 1'b0, 16'd0});
		rows.push_back('{16'h8000, 1'b1, 1'b0, 16'd0});
		rows.push_back('{16'h1000, 1'b0, 1'b0, 16'd0});
		rows.push_back('{16'h3244, 1'b0, 1'b0, 16'd0});
		rows.push_back('{16'h1922, 1'b0, 1'b0, 16'd0});
		rows.push_back('{16'h6488, 1'b1, 1'b0, 16'd0});
		rows.push_back('{16'hAAAA, 1'b0, 1'b0, 16'd0});
		rows.push_back('{16'h5555, 1'b1, 1'b0, 16'd0});
		foreach (rows[i]) send_sample(rows[i].x, rows[i].last, rows[i].known, rows[i].sinc);
		s_axis_tvalid <= 1'b0;

		// Zero scale: every sample gives exactly 1.0.
		write_scale(16'h0000);
		send_sample(16'h7FFF, 1'b0, 1'b1, 16'd16384);
		send_sample(16'h8000, 1'b1, 1'b1, 16'd16384);
		s_axis_tvalid <= 1'b0;

		// Random part across several scales, extremes included.
		scales = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h1000, 16'h0100, 16'hF000};
		for (int k = 0; k < 13; k++) begin
			if (k < scales.size()) write_scale(scales[k]);
			else write_scale(16'($urandom));
			in_quiet = (k == 4);
			out_quiet = (k == 4);
			for (int n = 0; n < 100; n++) begin
				case ($urandom_range(3))
					0: xv = 16'($urandom_range(63)) - 16'd32;
					default: xv = 16'($urandom);
				endcase
				send_sample(xv, 1'($urandom), 1'b0, 16'd0);
			end
			s_axis_tvalid <= 1'b0;
			in_quiet = 1'b0;
			out_quiet = 1'b0;
		end

		while (pending_sinc.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

/* filelist.f */
sv/scs_pkg.sv
sv/scs_reduce.sv
sv/scs_cordic.sv
sv/scs_divide.sv
sv/scaled_sinc_unit.sv
dv/scaled_sinc_unit_test.sv
